// ===== src/cse_pkg.sv =====
// ----------------------------------------------------------------------------
// cse_pkg
// Types and constants for the Chebyshev series evaluator.
// ----------------------------------------------------------------------------
package cse_pkg;

  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] REG_INTERVAL_A = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_INTERVAL_B = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_ORDER      = 2'd2;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_OUTSIDE = 2'd1;
  localparam logic [1:0] ST_EQUAL   = 2'd2;
  localparam logic [1:0] ST_SAT     = 2'd3;

  localparam logic signed [47:0] Q48_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [31:0] Q32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q32_MIN = 32'sh8000_0000;

  // restoring divider: 33 bit numerator magnitude shifted by 16
  localparam int unsigned DivW = 49;

  typedef struct packed {
    logic start;
    logic load;
    logic div_step;
    logic yset;
    logic mul0;
    logic mul1;
    logic mul2;
    logic step;
    logic emit;
  } cse_cmd_t;

  typedef struct packed {
    logic den_zero;
    logic div_last;
    logic j_zero;
    logic out_busy;
  } cse_stat_t;

endpackage

// ===== src/cse_ctrl.sv =====
// ----------------------------------------------------------------------------
// cse_ctrl
// Sequencer: interval division, then one multiply-add pass per coefficient.
// ----------------------------------------------------------------------------
module cse_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              opcode,
  output logic              in_stall,
  input  cse_pkg::cse_stat_t stat,
  output cse_pkg::cse_cmd_t  cmd
);
  import cse_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_DIV  = 8'b0000_0010,
    S_YSET = 8'b0000_0100,
    S_MUL0 = 8'b0000_1000,
    S_MUL1 = 8'b0001_0000,
    S_MUL2 = 8'b0010_0000,
    S_STEP = 8'b0100_0000,
    S_EMIT = 8'b1000_0000
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (opcode == OP_EVAL) begin
            cmd.start  = 1'b1;
            state_next = S_DIV;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      S_DIV: begin
        if (stat.den_zero) begin
          state_next = S_EMIT;
        end else begin
          cmd.div_step = 1'b1;
          if (stat.div_last) state_next = S_YSET;
        end
      end
      S_YSET: begin
        cmd.yset   = 1'b1;
        state_next = S_MUL0;
      end
      S_MUL0: begin
        cmd.mul0   = 1'b1;
        state_next = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = S_STEP;
      end
      S_STEP: begin
        cmd.step   = 1'b1;
        state_next = stat.j_zero ? S_EMIT : S_MUL0;
      end
      S_EMIT: begin
        if (!stat.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== src/cse_dp.sv =====
// ----------------------------------------------------------------------------
// cse_dp
// Datapath: config registers, coefficient memory, divider, split multiplier,
// Clenshaw accumulators and output register.
// ----------------------------------------------------------------------------
module cse_dp #(
  parameter int MAX_TERMS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [cse_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [31:0]                   cfg_data,
  input  logic [5:0]                    coeff_index,
  input  logic signed [31:0]            coeff_value,
  input  logic signed [31:0]            point,
  input  cse_pkg::cse_cmd_t             cmd,
  output cse_pkg::cse_stat_t            stat,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [31:0]            series_value,
  output logic [1:0]                    status
);
  import cse_pkg::*;

  localparam int AW = $clog2(MAX_TERMS);

  logic signed [31:0] interval_a, interval_b;
  logic [5:0]         series_order;

  logic signed [31:0] mem [MAX_TERMS];
  logic signed [31:0] rdata;
  logic               rd_ok;

  logic signed [33:0] x34, a34, b34, num, den;
  logic [32:0]        nmag;
  logic [31:0]        dmag;
  logic               outside_now;

  logic [31:0]        dvs;
  logic [31:0]        rem;
  logic [DivW-1:0]    dvd;
  logic [5:0]         cnt;
  logic               qneg, den_zero, outside, sat;
  logic [32:0]        tmp, diff;

  logic signed [31:0] y;
  logic [31:0]        ymag;
  logic [5:0]         j;
  logic signed [47:0] d, dd;
  logic [32:0]        mp;
  logic [46:0]        mq;
  logic               pneg;
  logic [56:0]        pp;
  logic [79:0]        acc;
  logic               ovf;
  logic [46:0]        qmag;
  logic signed [49:0] qs;
  logic signed [31:0] c;
  logic signed [50:0] sum_loop, sum_fin;
  logic signed [31:0] res;

  // interval mapping operands
  assign x34  = 34'(point);
  assign a34  = 34'(interval_a);
  assign b34  = 34'(interval_b);
  assign num  = (x34 <<< 1) - a34 - b34;
  assign den  = a34 - b34;
  assign nmag = num[33] ? 33'(-num) : num[32:0];
  assign dmag = den[33] ? 32'(-den) : den[31:0];
  assign outside_now = ((point < interval_a) && (point < interval_b)) ||
                       ((point > interval_a) && (point > interval_b));

  assign tmp  = {rem, dvd[DivW-1]};
  assign diff = tmp - {1'b0, dvs};

  // multiplier operands: 2y in the loop, y for the final term
  assign ymag = y[31] ? 32'(-y) : 32'(y);
  assign mp   = (j == 6'd0) ? {1'b0, ymag} : {ymag, 1'b0};
  assign mq   = d[47] ? 47'(-d) : d[46:0];
  assign pneg = y[31] ^ d[47];

  assign ovf  = acc > (80'd1 << 62);
  assign qmag = ovf ? Q48_MAX[46:0] : acc[62:16];
  assign qs   = pneg ? -50'(qmag) : 50'(qmag);
  assign c    = rd_ok ? rdata : 32'sd0;

  assign sum_loop = 51'(qs) - 51'(dd) + 51'(c);
  assign sum_fin  = 51'(qs) - 51'(dd) + 51'(c >>> 1);

  assign stat.den_zero = den_zero;
  assign stat.div_last = (cnt == 6'd0);
  assign stat.j_zero   = (j == 6'd0);
  assign stat.out_busy = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      interval_a   <= -32'sd65536;
      interval_b   <= 32'sd65536;
      series_order <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INTERVAL_A: interval_a   <= cfg_data;
        REG_INTERVAL_B: interval_b   <= cfg_data;
        REG_ORDER:      series_order <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && (32'(coeff_index) < MAX_TERMS)) begin
      mem[AW'(coeff_index)] <= coeff_value;
    end
    if (cmd.mul0) begin
      rdata <= mem[AW'(j)];
      rd_ok <= (32'(j) < MAX_TERMS);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      dvs      <= dmag;
      rem      <= '0;
      dvd      <= {nmag, 16'd0};
      cnt      <= 6'(DivW - 1);
      qneg     <= num[33] ^ den[33];
      den_zero <= (interval_a == interval_b);
      outside  <= outside_now;
      sat      <= 1'b0;
      j        <= series_order;
      d        <= '0;
      dd       <= '0;
    end
    if (cmd.div_step) begin
      if (!diff[32]) begin
        rem <= diff[31:0];
      end else begin
        rem <= tmp[31:0];
      end
      dvd <= {dvd[DivW-2:0], ~diff[32]};
      cnt <= cnt - 6'd1;
    end
    if (cmd.yset) begin
      if (qneg) begin
        if (dvd > (49'd1 << 31)) begin
          y   <= Q32_MIN;
          sat <= 1'b1;
        end else begin
          y <= 32'(-dvd);
        end
      end else begin
        if (dvd > 49'(Q32_MAX)) begin
          y   <= Q32_MAX;
          sat <= 1'b1;
        end else begin
          y <= 32'(dvd);
        end
      end
    end
    if (cmd.mul0) begin
      pp <= mp * 57'(mq[23:0]);
    end
    if (cmd.mul1) begin
      acc <= 80'(pp);
      pp  <= 57'(mp * 56'(mq[46:24]));
    end
    if (cmd.mul2) begin
      acc <= acc + (80'(pp) << 24);
    end
    if (cmd.step) begin
      if (j == 6'd0) begin
        if (sum_fin > 51'(Q32_MAX)) begin
          res <= Q32_MAX;
          sat <= 1'b1;
        end else if (sum_fin < 51'(Q32_MIN)) begin
          res <= Q32_MIN;
          sat <= 1'b1;
        end else begin
          res <= 32'(sum_fin);
          if (ovf) sat <= 1'b1;
        end
      end else begin
        dd <= d;
        j  <= j - 6'd1;
        if (sum_loop > 51'(Q48_MAX)) begin
          d   <= Q48_MAX;
          sat <= 1'b1;
        end else if (sum_loop < -51'(Q48_MAX)) begin
          d   <= -Q48_MAX;
          sat <= 1'b1;
        end else begin
          d <= 48'(sum_loop);
          if (ovf) sat <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (den_zero) begin
        series_value <= '0;
        status       <= ST_EQUAL;
      end else begin
        series_value <= res;
        status       <= outside ? ST_OUTSIDE : (sat ? ST_SAT : ST_OK);
      end
    end
  end

endmodule

// ===== src/chebyshev_series_evaluator.sv =====
// ----------------------------------------------------------------------------
// chebyshev_series_evaluator
// Clenshaw evaluation of a Chebyshev series in signed Q16.16.
// ----------------------------------------------------------------------------
//   channel  signals                                 direction
//   in       in_valid/in_stall, opcode, coeff_index,  into block
//            coeff_value, point
//   out      out_valid/out_stall, series_value,       out of block
//            status
//   cfg      cfg_we, cfg_index, cfg_data              into block
//
// A load item is written into the coefficient store when accepted. An
// evaluate item maps the point with a restoring divider, then a 33x24
// multiplier runs two partial products per Clenshaw term.
// If a equals b the divider and the Clenshaw terms are skipped.
// Synchronous reset clears control and config; the coefficient store is not
// cleared. One finished result may wait in the output register under stall.
// ----------------------------------------------------------------------------
module chebyshev_series_evaluator #(
  parameter int MAX_TERMS = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        opcode,
  input  logic [5:0]                  coeff_index,
  input  logic signed [31:0]          coeff_value,
  input  logic signed [31:0]          point,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [31:0]          series_value,
  output logic [1:0]                  status,
  input  logic                        cfg_we,
  input  logic [cse_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [31:0]                 cfg_data
);
  import cse_pkg::*;

  cse_cmd_t  cmd;
  cse_stat_t stat;

  cse_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .opcode   (opcode),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  cse_dp #(
    .MAX_TERMS (MAX_TERMS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .coeff_index  (coeff_index),
    .coeff_value  (coeff_value),
    .point        (point),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .series_value (series_value),
    .status       (status)
  );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives load and evaluate items into the Chebyshev series evaluator, with
// random idling on both channels, and checks every result against a
// fixed-point Clenshaw predictor kept in a small scoreboard class.
// ----------------------------------------------------------------------------
module testbench;
  import cse_pkg::*;

  localparam longint D_MAX = 64'sd140737488355327;
  localparam longint D_MIN = -64'sd140737488355327;
  localparam longint W_MAX = 64'sd2147483647;
  localparam longint W_MIN = -64'sd2147483648;

  typedef struct {
    logic signed [31:0] value;
    logic [1:0]         status;
  } series_result_t;

  class series_scoreboard;
    longint              ival_a;
    longint              ival_b;
    int                  order;
    longint              coeffs [64];
    bit                  written [64];
    series_result_t      pending [$];
    int                  errors;
    int                  evals;
    int                  loads;
    int                  sat_seen [4];

    function new();
      ival_a = -65536;
      ival_b = 65536;
      order  = 0;
      errors = 0;
      evals  = 0;
      loads  = 0;
      for (int k = 0; k < 64; k++) begin
        coeffs[k]  = 0;
        written[k] = 0;
      end
    endfunction

    function longint clip(longint v, longint lo, longint hi, ref bit sat);
      if (v > hi) begin
        sat = 1;
        return hi;
      end
      if (v < lo) begin
        sat = 1;
        return lo;
      end
      return v;
    endfunction

    function longint fix_mul(longint p, longint q, ref bit sat);
      longint unsigned mp;
      longint unsigned mq;
      longint unsigned prod;
      bit              neg;
      longint          r;
      mp  = p < 0 ? -p : p;
      mq  = q < 0 ? -q : q;
      neg = (p < 0) != (q < 0);
      if (mp != 0 && mq > (64'd1 << 62) / mp) begin
        sat = 1;
        return neg ? D_MIN : D_MAX;
      end
      prod = (mp * mq) >> 16;
      r = longint'(prod);
      if (neg) r = -r;
      return clip(r, D_MIN, D_MAX, sat);
    endfunction

    function void note_item(logic op, logic [5:0] idx, logic signed [31:0] cv,
                            logic signed [31:0] pt);
      series_result_t e;
      longint x, num, den, y, d, dd, sv, c0, res;
      bit sat;
      if (op == OP_LOAD) begin
        coeffs[idx]  = cv;
        written[idx] = 1;
        loads++;
        return;
      end
      evals++;
      x = pt;
      sat = 0;
      if (ival_a == ival_b) begin
        e.value  = 0;
        e.status = ST_EQUAL;
      end else begin
        num = 2 * x - ival_a - ival_b;
        den = ival_a - ival_b;
        y = clip((num * 65536) / den, W_MIN, W_MAX, sat);
        d = 0;
        dd = 0;
        for (int j = order; j >= 1; j--) begin
          sv = d;
          d = clip(fix_mul(2 * y, d, sat) - dd + coeffs[j], D_MIN, D_MAX, sat);
          dd = sv;
        end
        c0 = coeffs[0];
        c0 = (c0 - (c0 & 1)) / 2;
        res = clip(fix_mul(y, d, sat) - dd + c0, W_MIN, W_MAX, sat);
        e.value = res[31:0];
        if ((x < ival_a && x < ival_b) || (x > ival_a && x > ival_b))
          e.status = ST_OUTSIDE;
        else
          e.status = sat ? ST_SAT : ST_OK;
      end
      sat_seen[e.status]++;
      pending.push_back(e);
    endfunction

    function void check_result(logic signed [31:0] val, logic [1:0] st);
      series_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result value=%0d status=%0d", $time, val, st);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (val !== e.value) begin
        $display("%0t: series_value expected %0d actual %0d", $time, e.value, val);
        errors++;
      end
      if (st !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, st);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic               opcode;
  logic [5:0]         coeff_index;
  logic signed [31:0] coeff_value;
  logic signed [31:0] point;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] series_value;
  logic [1:0]         status;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [31:0]        cfg_data;

  series_scoreboard   board;
  bit                 calm;
  longint             cycles = 0;

  chebyshev_series_evaluator i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .coeff_index(coeff_index),
    .coeff_value(coeff_value), .point(point),
    .out_valid(out_valid), .out_stall(out_stall),
    .series_value(series_value), .status(status),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("chebyshev_series_evaluator test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall)
      board.note_item(opcode, coeff_index, coeff_value, point);
    if (!rst && out_valid && !out_stall)
      board.check_result(series_value, status);
  end

  always @(negedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= calm ? 1'b0 : ($urandom_range(99) < 36);
  end

  // valid stays up after acceptance until the next item or an idle drops it
  task automatic send_item(logic op, logic [5:0] idx, logic signed [31:0] cv,
                           logic signed [31:0] pt);
    if (!calm) begin
      while ($urandom_range(99) < 36) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid    <= 1'b1;
    opcode      <= op;
    coeff_index <= idx;
    coeff_value <= cv;
    point       <= pt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    if (idx == REG_INTERVAL_A) board.ival_a = longint'(signed'(val));
    else if (idx == REG_INTERVAL_B) board.ival_b = longint'(signed'(val));
    else if (idx == REG_ORDER) board.order = val[5:0];
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (400) @(negedge clk);
  endtask

  task automatic set_interval(logic signed [31:0] a, logic signed [31:0] b, int ord);
    drain();
    write_reg(REG_INTERVAL_A, a);
    write_reg(REG_INTERVAL_B, b);
    write_reg(REG_ORDER, 32'(ord));
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [31:0] rand_coeff();
    case ($urandom_range(5))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return $urandom;
      default: return $signed($urandom_range(262143)) - 131072;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_point(longint a, longint b);
    longint lo, hi;
    lo = a < b ? a : b;
    hi = a < b ? b : a;
    case ($urandom_range(9))
      0: return $urandom;
      1: return 32'(a);
      2: return 32'(b);
      default: return 32'(lo + ((hi - lo) * $urandom_range(1000)) / 1000);
    endcase
  endfunction

  task automatic fill_store();
    for (int k = 0; k < 64; k++) send_item(OP_LOAD, 6'(k), rand_coeff(), $urandom);
  endtask

  initial begin
    int n;
    board       = new();
    calm        = 0;
    rst         = 1'b1;
    in_valid    = 1'b0;
    opcode      = OP_LOAD;
    coeff_index = '0;
    coeff_value = '0;
    point       = '0;
    out_stall   = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: order 0 at reset settings, c0 extremes, ends, outside points
    send_item(OP_LOAD, 0, 32'sh0001_0001, 32'sh7FFF_FFFF);
    send_item(OP_EVAL, 0, 0, -32'sd65536);
    send_item(OP_EVAL, 0, 0, 32'sd65536);
    send_item(OP_EVAL, 0, 0, 32'sh8000_0000);
    send_item(OP_EVAL, 0, 0, 32'sh7FFF_FFFF);
    send_item(OP_LOAD, 0, 32'sh8000_0000, 0);
    send_item(OP_EVAL, 63, 32'shFFFF_FFFF, 0);
    send_item(OP_LOAD, 1, 32'sh7FFF_FFFF, 0);
    send_item(OP_LOAD, 63, 32'sh7FFF_FFFF, 0);
    fill_store();
    set_interval(32'sh8000_0000, 32'sh7FFF_FFFF, 63);
    send_item(OP_EVAL, 0, 0, 32'sh8000_0000);
    send_item(OP_EVAL, 0, 0, 32'sh7FFF_FFFF);
    send_item(OP_EVAL, 0, 0, 0);
    set_interval(32'sd1, 32'sd0, 5);
    send_item(OP_EVAL, 0, 0, 32'sh7FFF_FFFF);
    send_item(OP_EVAL, 0, 0, 32'sd1);
    set_interval(32'sd12345, 32'sd12345, 3);
    send_item(OP_EVAL, 0, 0, 32'sd12345);
    send_item(OP_EVAL, 0, 0, 32'sh8000_0000);

    for (int phase = 0; phase < 12; phase++) begin
      longint a, b;
      calm = (phase == 4);
      case (phase % 4)
        0: begin
          a = -65536;
          b = 65536;
        end
        1: begin
          a = $signed($urandom);
          b = $signed($urandom);
        end
        2: begin
          a = $signed($urandom_range(1 << 20)) - (1 << 19);
          b = a + $urandom_range(1 << 18) + 1;
        end
        default: begin
          a = $signed($urandom_range(200000)) - 100000;
          b = (phase == 7) ? a : $signed($urandom_range(200000)) - 100000;
        end
      endcase
      n = (phase == 0) ? 63 : (phase < 3 ? $urandom_range(63) : $urandom_range(12));
      set_interval(32'(a), 32'(b), n);
      if (phase == 6) fill_store();
      for (int k = 0; k < 60; k++) begin
        if ($urandom_range(3) == 0)
          send_item(OP_LOAD, 6'($urandom_range(63)), rand_coeff(), $urandom);
        else
          send_item(OP_EVAL, 6'($urandom), $urandom, rand_point(a, b));
      end
    end
    calm = 0;

    drain();
    $display("%0d loads, %0d evaluations; status counts ok/outside/equal/sat: %0d/%0d/%0d/%0d",
             board.loads, board.evals, board.sat_seen[0], board.sat_seen[1],
             board.sat_seen[2], board.sat_seen[3]);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("chebyshev_series_evaluator test passed");
    else
      $display("chebyshev_series_evaluator test failed");
    $finish;
  end
endmodule
